FILE: src/fzc_pkg.sv
package fzc_pkg;

	// zone codes
	localparam logic [3:0] ZONE_NONE   = 4'd0;
	localparam logic [3:0] ZONE_CENTER = 4'd5;

	// band along one axis
	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;
	localparam logic [1:0] BAND_ON   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_X_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_Y_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_BUZZ_HOLDOFF = 2'd2;

	localparam logic [15:0] HOLDOFF_RESET   = 16'd250;
	localparam logic [31:0] BUZZ_TIME_RESET = 32'hFFFF_FFFF;

	// classified request waiting for the back end
	typedef struct packed {
		logic [3:0]  zone_cand;
		logic [31:0] time_ms;
	} fzc_item_t;

	// strict compare of a reading against +/- threshold
	function automatic logic [1:0] band_of(input logic signed [15:0] v,
			input logic [14:0] t);
		logic signed [16:0] vs;
		logic signed [16:0] tp;
		logic signed [16:0] tn;
		logic [1:0]         b;
		vs = 17'(v);
		tp = $signed({2'b00, t});
		tn = -tp;
		priority if (vs < tn) begin
			b = BAND_LOW;
		end else if (vs > tp) begin
			b = BAND_HIGH;
		end else if (vs > tn && vs < tp) begin
			b = BAND_MID;
		end else begin
			b = BAND_ON;
		end
		return b;
	endfunction

	// zone = 1 + 3*row + col, none when either axis sits on a threshold
	function automatic logic [3:0] zone_of(input logic [1:0] row, input logic [1:0] col);
		logic [3:0] z;
		if (row == BAND_ON || col == BAND_ON) begin
			z = ZONE_NONE;
		end else begin
			z = 4'd1 + 4'd3 * {2'b00, row} + {2'b00, col};
		end
		return z;
	endfunction

endpackage

FILE: src/fzc_sample_if.sv
interface fzc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] force_x;
	logic signed [15:0] force_y;
	logic [31:0]        time_ms;

	modport source(output valid, output force_x, output force_y, output time_ms,
		input ready);
	modport sink(input valid, input force_x, input force_y, input time_ms,
		output ready);
endinterface

FILE: src/fzc_result_if.sv
interface fzc_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] zone;
	logic       zone_changed;
	logic       center_left;
	logic       buzz_pulse;

	modport source(output valid, output zone, output zone_changed,
		output center_left, output buzz_pulse, input ready);
	modport sink(input valid, input zone, input zone_changed,
		input center_left, input buzz_pulse, output ready);
endinterface

FILE: src/force_zone_classifier.sv
// Force zone classifier: each request on the sample channel carries a signed X,Y load-cell
// reading and a millisecond timestamp and yields exactly one result with the pad zone
// (1-9, back row first, left to right; 0 until a first zone is seen), a zone-changed flag,
// a center-left flag and a buzz pulse. A reading exactly on +/- a threshold keeps the
// previous zone. The buzz fires when the center is left and the wrapping 32-bit time since
// the last buzz exceeds buzz_holdoff_ms. The block takes one sample per clock cycle while
// the queue has room. The sample is classified and written into the queue at the edge that
// takes it. The back end then pops it, updates the zone/buzz state and loads the output
// register, once that register is empty or result.ready is high. The result is presented
// from the output register. The queue of QUEUE_DEPTH entries, together with the output
// register, holds QUEUE_DEPTH + 1 requests while the result side stalls. When the queue
// fills, sample.ready drops. Registers (APB, byte address 4*index): 0 x_threshold
// (15 bits), 1 y_threshold (15 bits), 2 buzz_holdoff_ms (16 bits, reset 250). Write them
// only while no sample is in flight.
module force_zone_classifier #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	fzc_sample_if.sink    sample,
	fzc_result_if.source  result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import fzc_pkg::*;

	// configuration registers
	logic [14:0] x_thr_q;
	logic [14:0] y_thr_q;
	logic [15:0] holdoff_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	// front to queue to back
	logic      push;
	logic      q_full;
	logic      q_not_empty;
	logic      pop;
	fzc_item_t item_in;
	fzc_item_t item_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_thr_q   <= '0;
			y_thr_q   <= '0;
			holdoff_q <= HOLDOFF_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_X_THRESHOLD: begin
					x_thr_q <= pwdata[14:0];
				end
				REG_Y_THRESHOLD: begin
					y_thr_q <= pwdata[14:0];
				end
				REG_BUZZ_HOLDOFF: begin
					holdoff_q <= pwdata[15:0];
				end
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_X_THRESHOLD:  prdata = {17'b0, x_thr_q};
			REG_Y_THRESHOLD:  prdata = {17'b0, y_thr_q};
			REG_BUZZ_HOLDOFF: prdata = {16'b0, holdoff_q};
			default:          prdata = '0;
		endcase
	end

	// front: sort the reading into a candidate zone
	fzc_front u_front (
		.sample      (sample),
		.x_threshold (x_thr_q),
		.y_threshold (y_thr_q),
		.q_full      (q_full),
		.push        (push),
		.item        (item_in)
	);

	// short queue decoupling the two sides
	fzc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item_in   (item_in),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.item_out  (item_out)
	);

	// back: held zone, buzz timing and output register
	fzc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.buzz_holdoff_ms (holdoff_q),
		.not_empty       (q_not_empty),
		.item            (item_out),
		.pop             (pop),
		.result          (result)
	);

endmodule

FILE: src/fzc_front.sv
module fzc_front (
	fzc_sample_if.sink            sample,
	input  logic [14:0]           x_threshold,
	input  logic [14:0]           y_threshold,
	input  logic                  q_full,
	output logic                  push,
	output fzc_pkg::fzc_item_t    item
);
	import fzc_pkg::*;

	logic [1:0] col;
	logic [1:0] row;

	assign col = band_of(sample.force_x, x_threshold);
	assign row = band_of(sample.force_y, y_threshold);

	assign sample.ready   = !q_full;
	assign push           = sample.valid && !q_full;
	assign item.zone_cand = zone_of(row, col);
	assign item.time_ms   = sample.time_ms;

endmodule

FILE: src/fzc_queue.sv
module fzc_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fzc_pkg::fzc_item_t item_in,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output fzc_pkg::fzc_item_t item_out
);
	import fzc_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fzc_item_t       entries_q [DEPTH];
	logic [IW-1:0]   wr_q;
	logic [IW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign item_out  = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");

endmodule

FILE: src/fzc_back.sv
module fzc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        buzz_holdoff_ms,
	input  logic               not_empty,
	input  fzc_pkg::fzc_item_t item,
	output logic               pop,
	fzc_result_if.source       result
);
	import fzc_pkg::*;

	logic [3:0]  held_zone_q;
	logic [31:0] last_buzz_q;
	logic        out_valid_q;
	logic [3:0]  zone_q;
	logic        changed_q;
	logic        cleft_q;
	logic        buzz_q;

	logic [3:0]  zone_new;
	logic        changed;
	logic        cleft;
	logic [31:0] elapsed;
	logic        buzz;

	assign pop = not_empty && (!out_valid_q || result.ready);

	// hold the last zone when the sample sits on a threshold
	assign zone_new = (item.zone_cand != ZONE_NONE) ? item.zone_cand : held_zone_q;
	assign changed  = (zone_new != held_zone_q);
	assign cleft    = changed && (held_zone_q == ZONE_CENTER);
	// wrapping difference
	assign elapsed  = item.time_ms - last_buzz_q;
	assign buzz     = cleft && (elapsed > {16'b0, buzz_holdoff_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_zone_q <= ZONE_NONE;
			last_buzz_q <= BUZZ_TIME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				held_zone_q <= zone_new;
				out_valid_q <= 1'b1;
				if (buzz) begin
					last_buzz_q <= item.time_ms;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			zone_q    <= zone_new;
			changed_q <= changed;
			cleft_q   <= cleft;
			buzz_q    <= buzz;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.zone         = zone_q;
	assign result.zone_changed = changed_q;
	assign result.center_left  = cleft_q;
	assign result.buzz_pulse   = buzz_q;

	buzz_needs_cleft: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && buzz_q |-> cleft_q) else $error("buzz without center leave");
	cleft_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cleft_q |-> changed_q) else $error("center leave without change");
	held_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> held_zone_q == zone_q) else $error("held zone differs from result");
	buzz_stamps_time: assert property (@(posedge clk) disable iff (!arst_n)
		pop && buzz |=> last_buzz_q == $past(item.time_ms))
		else $error("buzz time not recorded");

endmodule

FILE: tb/sv/force_zone_classifier_tb.sv
`timescale 1ns / 100ps

module force_zone_classifier_tb;
	import fzc_pkg::*;

	// run limits, in clock cycles
	localparam int LIMIT_CYCLES   = 400000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int MAX_PRINTED    = 200;

	// register index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// one sample request as it waits to be offered
	typedef struct packed {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic [31:0]        ms;
	} sample_t;

	// one classified result
	typedef struct packed {
		logic [3:0] zone;
		logic       changed;
		logic       cleft;
		logic       buzz;
	} zone_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fzc_sample_if smp();
	fzc_result_if res();

	force_zone_classifier uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the configuration registers
	logic [14:0] x_thr;
	logic [14:0] y_thr;
	logic [15:0] buzz_holdoff;

	// shadow of the classifier state
	logic [3:0]  cur_zone;
	logic [31:0] last_buzz_ms;

	// requests waiting to be offered, results waiting to arrive
	sample_t      sample_backlog[$];
	zone_result_t zone_expect_q[$];

	int err_count;
	int cycle_count;

	// traffic shaping for the driver and the ready process
	bit no_idle;
	int hold_phase;
	int seen_hold_phase;
	int tx_gap;
	int rx_stall;
	bit sample_taken;

	// stimulus generator state
	bit          gen_center;
	logic [31:0] gen_ms;

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("force_zone_classifier_tb: FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	// strict band of one reading against +/- threshold
	function automatic logic [1:0] axis_band(input int v, input int t);
		if (v < -t) begin
			return BAND_LOW;
		end
		if (v > t) begin
			return BAND_HIGH;
		end
		if (v > -t && v < t) begin
			return BAND_MID;
		end
		return BAND_ON;
	endfunction

	// work out the result of one accepted sample and advance the shadow state
	task automatic predict_zone(input logic signed [15:0] fx, input logic signed [15:0] fy,
			input logic [31:0] ms);
		logic [1:0]   col;
		logic [1:0]   row;
		logic [31:0]  elapsed;
		zone_result_t r;
		col = axis_band(int'(fx), int'(x_thr));
		row = axis_band(int'(fy), int'(y_thr));
		r = '0;
		r.zone = cur_zone;
		// a reading on a threshold keeps the held zone
		if (col != BAND_ON && row != BAND_ON) begin
			r.zone = 4'(1 + 3 * int'(row) + int'(col));
		end
		if (r.zone != cur_zone) begin
			r.changed = 1'b1;
			if (cur_zone == ZONE_CENTER) begin
				r.cleft = 1'b1;
				// wrapping elapsed time since the last buzz
				elapsed = ms - last_buzz_ms;
				if (elapsed > {16'd0, buzz_holdoff}) begin
					r.buzz = 1'b1;
					last_buzz_ms = ms;
				end
			end
			cur_zone = r.zone;
		end
		zone_expect_q.push_back(r);
	endtask

	// one apb transfer, setup then access
	task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] data,
			output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write a register, mirror it with the bits above its width dropped, read it back
	task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(idx, 1'b1, value, rd);
		case (idx)
			REG_X_THRESHOLD: begin
				x_thr = value[14:0];
				want = {17'd0, x_thr};
			end
			REG_Y_THRESHOLD: begin
				y_thr = value[14:0];
				want = {17'd0, y_thr};
			end
			REG_BUZZ_HOLDOFF: begin
				buzz_holdoff = value[15:0];
				want = {16'd0, buzz_holdoff};
			end
			default: begin
				// out of range: nothing changes, nothing to read back
				return;
			end
		endcase
		apb_access(idx, 1'b0, '0, rd);
		if (rd !== want) begin
			flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, want));
		end
	endtask

	task automatic add_sample(input logic [15:0] fx, input logic [15:0] fy,
			input logic [31:0] ms);
		sample_t s;
		s.fx = fx;
		s.fy = fy;
		s.ms = ms;
		sample_backlog.push_back(s);
	endtask

	// a reading inside the wanted band, often right next to the threshold
	function automatic logic [15:0] pick_axis(input logic [1:0] band, input int t);
		int         v;
		logic [1:0] b;
		bit         near;
		b = band;
		// empty center band at zero threshold, no high band at full scale
		if (b == BAND_MID && t == 0) begin
			b = ($urandom_range(0, 1) != 0) ? BAND_LOW : BAND_HIGH;
		end
		if (b == BAND_HIGH && t == 32767) begin
			b = BAND_LOW;
		end
		near = ($urandom_range(0, 3) == 0);
		case (b)
			BAND_LOW: begin
				v = near ? -t - 1 : -32768 + int'($urandom_range(0, 32767 - t));
			end
			BAND_MID: begin
				if (near) begin
					v = ($urandom_range(0, 1) != 0) ? t - 1 : 1 - t;
				end else begin
					v = 1 - t + int'($urandom_range(0, 2 * t - 2));
				end
			end
			BAND_HIGH: begin
				v = near ? t + 1 : t + 1 + int'($urandom_range(0, 32766 - t));
			end
			default: begin
				v = ($urandom_range(0, 1) != 0) ? t : -t;
			end
		endcase
		return 16'(v);
	endfunction

	// timestamps mostly creep forward around the holdoff, sometimes jump or wrap
	function automatic logic [31:0] next_stamp();
		int r;
		int h;
		r = $urandom_range(0, 99);
		h = int'(buzz_holdoff);
		if (r < 60) begin
			gen_ms = gen_ms + $urandom_range(0, 2 * h + 2);
		end else if (r < 80) begin
			gen_ms = gen_ms + $urandom_range(0, 3);
		end else if (r < 90) begin
			gen_ms = $urandom;
		end else begin
			gen_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * h + 2);
		end
		return gen_ms;
	endfunction

	// random samples that hop in and out of the center, with some noise
	task automatic queue_random_samples(input int n);
		logic [1:0]  rb;
		logic [1:0]  cb;
		logic [15:0] fx;
		logic [15:0] fy;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				// full-scale noise
				fx = 16'($urandom);
				fy = 16'($urandom);
				gen_center = 1'b0;
			end else begin
				if ($urandom_range(0, 99) < (gen_center ? 30 : 55)) begin
					rb = BAND_MID;
					cb = BAND_MID;
				end else begin
					rb = 2'($urandom_range(0, 2));
					cb = 2'($urandom_range(0, 2));
					if (rb == BAND_MID && cb == BAND_MID) begin
						cb = ($urandom_range(0, 1) != 0) ? BAND_LOW : BAND_HIGH;
					end
					// now and then sit exactly on a threshold
					if ($urandom_range(0, 99) < 8) begin
						rb = BAND_ON;
					end else if ($urandom_range(0, 99) < 8) begin
						cb = BAND_ON;
					end
				end
				fx = pick_axis(cb, int'(x_thr));
				fy = pick_axis(rb, int'(y_thr));
				gen_center = (rb == BAND_MID && cb == BAND_MID);
			end
			add_sample(fx, fy, next_stamp());
		end
	endtask

	// nothing queued, nothing offered, nothing in flight
	task automatic wait_for_idle();
		do begin
			@(posedge clk);
		end while (sample_backlog.size() != 0 || smp.valid || zone_expect_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input int n, input logic [31:0] xv, input logic [31:0] yv,
			input logic [31:0] hv, input bit burst, input bit squeeze);
		wait_for_idle();
		set_register(REG_X_THRESHOLD, xv);
		set_register(REG_Y_THRESHOLD, yv);
		set_register(REG_BUZZ_HOLDOFF, hv);
		no_idle = burst;
		// receiver holds off for a long stretch while requests keep coming
		if (squeeze) begin
			hold_phase++;
		end
		queue_random_samples(n);
		wait_for_idle();
		no_idle = 1'b0;
	endtask

	// sample driver: inputs change on the falling edge
	always @(negedge clk) begin : sample_driver
		sample_t s;
		if (arst_n) begin
			// request just taken: draw the gap before the next one
			if (smp.valid && sample_taken) begin
				tx_gap = no_idle ? 0 : idle_len();
			end
			if (!smp.valid || sample_taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					smp.valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					s = sample_backlog.pop_front();
					smp.valid   <= 1'b1;
					smp.force_x <= s.fx;
					smp.force_y <= s.fy;
					smp.time_ms <= s.ms;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// result ready: random stalls, plus the long hold-off when asked
	always @(negedge clk) begin : result_ready
		if (arst_n) begin
			if (hold_phase != seen_hold_phase) begin
				seen_hold_phase = hold_phase;
				rx_stall = SQUEEZE_CYCLES;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res.ready <= 1'b0;
			end else if (no_idle || $urandom_range(0, 99) < 65) begin
				res.ready <= 1'b1;
			end else begin
				rx_stall = idle_len();
				res.ready <= 1'b0;
			end
		end
	end

	// monitor: check results and predict accepted requests on the rising edge
	always @(posedge clk) begin : result_monitor
		zone_result_t got;
		zone_result_t want;
		sample_taken <= smp.valid && smp.ready;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.zone    = res.zone;
				got.changed = res.zone_changed;
				got.cleft   = res.center_left;
				got.buzz    = res.buzz_pulse;
				if (zone_expect_q.size() == 0) begin
					flag_mismatch($sformatf("result with none expected: zone %0d", got.zone));
				end else begin
					want = zone_expect_q.pop_front();
					if (got.zone !== want.zone) begin
						flag_mismatch($sformatf("zone %0d, expected %0d", got.zone, want.zone));
					end
					if (got.changed !== want.changed) begin
						flag_mismatch($sformatf("zone_changed %b, expected %b",
							got.changed, want.changed));
					end
					if (got.cleft !== want.cleft) begin
						flag_mismatch($sformatf("center_left %b, expected %b",
							got.cleft, want.cleft));
					end
					if (got.buzz !== want.buzz) begin
						flag_mismatch($sformatf("buzz_pulse %b, expected %b",
							got.buzz, want.buzz));
					end
				end
			end
			if (smp.valid && smp.ready) begin
				predict_zone(smp.force_x, smp.force_y, smp.time_ms);
			end
		end
	end

	initial begin
		// known values on every input from time zero
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		smp.valid   = 1'b0;
		smp.force_x = '0;
		smp.force_y = '0;
		smp.time_ms = '0;
		res.ready   = 1'b0;
		err_count   = 0;
		cycle_count = 0;
		no_idle     = 1'b0;
		hold_phase  = 0;
		seen_hold_phase = 0;
		tx_gap      = 0;
		rx_stall    = 0;
		sample_taken = 1'b0;
		gen_center  = 1'b0;
		gen_ms      = '0;

		// reset state of the shadow
		x_thr        = '0;
		y_thr        = '0;
		buzz_holdoff = HOLDOFF_RESET;
		cur_zone     = ZONE_NONE;
		last_buzz_ms = BUZZ_TIME_RESET;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset thresholds of zero: on-threshold holds zone none, corners only
		add_sample(16'sd0, 16'sd0, 32'd0);
		add_sample(16'sd0, -16'sd32768, 32'd0);
		add_sample(-16'sd32768, -16'sd32768, 32'd1);
		add_sample(16'sd32767, 16'sd32767, 32'd2);
		add_sample(-16'sd1, 16'sd1, 32'd3);
		add_sample(16'sd1, -16'sd1, 32'd4);
		wait_for_idle();

		// junk above the register widths must be dropped; unused index ignored
		set_register(REG_X_THRESHOLD, 32'hFFFF_8064);
		set_register(REG_Y_THRESHOLD, 32'h0000_00C8);
		set_register(REG_BUZZ_HOLDOFF, 32'hABCD_00FA);
		set_register(REG_UNUSED, 32'hFFFF_FFFF);

		// holdoff boundary from the reset buzz time: 250 elapsed no buzz, 251 buzz
		add_sample(16'sd0, 16'sd0, 32'd5);
		add_sample(16'sd150, 16'sd0, 32'd249);
		add_sample(16'sd0, 16'sd0, 32'd249);
		add_sample(16'sd0, 16'sd0, 32'd250);
		add_sample(-16'sd150, 16'sd0, 32'd250);
		// exactly on each threshold: zone held
		add_sample(16'sd100, 16'sd0, 32'd300);
		add_sample(-16'sd100, 16'sd0, 32'd300);
		add_sample(16'sd0, 16'sd200, 32'd300);
		add_sample(16'sd0, -16'sd200, 32'd300);
		add_sample(16'sd0, 16'sd0, 32'd300);
		add_sample(16'sd0, -16'sd201, 32'd500);
		// timestamp wrap between center entry and leave
		add_sample(16'sd0, 16'sd0, 32'hFFFF_FF00);
		add_sample(16'sd0, 16'sd201, 32'h0000_0010);
		// walk the remaining zones and a full-scale corner
		add_sample(-16'sd150, -16'sd250, 32'h0000_0011);
		add_sample(16'sd150, -16'sd250, 32'h0000_0012);
		add_sample(16'sd150, 16'sd250, 32'h0000_0013);
		add_sample(16'sd150, 16'sd0, 32'h0000_0014);
		add_sample(16'sd0, 16'sd0, 32'h0000_0015);
		add_sample(-16'sd32768, 16'sd32767, 32'h0000_0020);

		// random phases across settings, extremes first
		run_phase(250, 32'd32767, 32'd32767, 32'd0, 1'b1, 1'b0);
		run_phase(250, 32'd0, 32'd0, 32'd65535, 1'b0, 1'b0);
		run_phase(250, $urandom_range(1, 3000), $urandom_range(1, 3000),
			$urandom_range(0, 500), 1'b0, 1'b1);
		run_phase(250, 32'd1, 32'd1, 32'd1, 1'b1, 1'b0);
		run_phase(250, $urandom, $urandom, $urandom, 1'b0, 1'b0);
		run_phase(250, $urandom_range(0, 32767), 32'd0, $urandom_range(0, 1000), 1'b0, 1'b0);
		run_phase(250, $urandom_range(1, 500), $urandom_range(1, 500), 32'd250, 1'b0, 1'b1);

		// let any stray result show up
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (zone_expect_q.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", zone_expect_q.size()));
		end
		if (err_count == 0) begin
			$display("force_zone_classifier_tb: PASS");
		end else begin
			$display("force_zone_classifier_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: force_zone_classifier.f
src/fzc_pkg.sv
src/fzc_sample_if.sv
src/fzc_result_if.sv
src/fzc_front.sv
src/fzc_queue.sv
src/fzc_back.sv
src/force_zone_classifier.sv
tb/sv/force_zone_classifier_tb.sv
